>>> src/scd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  // Default width of the byte position counter.
  localparam int POSITION_WIDTH_DEFAULT = 32;

  // Fixed header sizes of the container format, in bytes.
  localparam int FILE_HDR_BYTES = 8;
  localparam int SECT_HDR_BYTES = 14;

  // Configuration register indexes.
  localparam logic REG_MAGIC_WORD  = 1'b0;
  localparam logic REG_FILE_LENGTH = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_SECTION = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes carried on an error result.
  localparam logic [1:0] ERR_SHORT_FILE     = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC      = 2'd1;
  localparam logic [1:0] ERR_SHORT_TRAILING = 2'd2;
  localparam logic [1:0] ERR_LENGTH_OVERRUN = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] file_version;
    logic [31:0] section_tag;
    logic [15:0] section_version;
    logic [63:0] section_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        file_done;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [31:0] file_length;
  } cfg_t;

  // One processed beat: whether it yields a result, and the result itself.
  typedef struct packed {
    logic    emit;
    result_t result;
  } step_t;

endpackage

`default_nettype wire

>>> src/scd_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module scd_parse #(
  parameter int POSITION_WIDTH = scd_pkg::POSITION_WIDTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire scd_pkg::item_t item,
  input  wire scd_pkg::cfg_t  cfg,
  output scd_pkg::step_t      step
);

  localparam logic [1:0] PH_FILE = 2'd0;
  localparam logic [1:0] PH_SECT = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  localparam int CW = (POSITION_WIDTH > 32) ? POSITION_WIDTH : 32;
  localparam int HW = 8 * scd_pkg::SECT_HDR_BYTES;

  logic [POSITION_WIDTH-1:0] position, position_next, pos_e, pos_inc;
  logic [1:0]                phase, phase_next, phase_e;
  logic [3:0]                hdr_count, hdr_count_next, cnt_e;
  logic [HW-1:0]             header_shift, header_shift_next, hdr_view;
  logic [63:0]               section_remaining, section_remaining_next, rem_e;
  logic                      error_latched, error_latched_next, err_e;
  logic                      finished, finished_next, fin_e;
  logic [31:0]               version_latch, version_latch_next, ver_e;
  logic [CW-1:0]             fl_ext, pos_ext, pos_inc_ext;
  logic [31:0]               left_now, left_next;
  logic                      done;
  logic [63:0]               sect_len;

  always_comb begin
    // A start of file clears the parser before its byte is taken.
    if (item.start_of_file) begin
      pos_e   = '0;
      phase_e = PH_FILE;
      cnt_e   = '0;
      rem_e   = '0;
      err_e   = 1'b0;
      fin_e   = 1'b0;
      ver_e   = '0;
    end else begin
      pos_e   = position;
      phase_e = phase;
      cnt_e   = hdr_count;
      rem_e   = section_remaining;
      err_e   = error_latched;
      fin_e   = finished;
      ver_e   = version_latch;
    end

    pos_inc     = pos_e + 1'b1;
    fl_ext      = CW'(cfg.file_length);
    pos_ext     = CW'(pos_e);
    pos_inc_ext = CW'(pos_inc);
    left_now    = (fl_ext > pos_ext) ? 32'(fl_ext - pos_ext) : '0;
    left_next   = (fl_ext > pos_inc_ext) ? 32'(fl_ext - pos_inc_ext) : '0;
    done        = (pos_inc_ext == fl_ext);

    hdr_view = header_shift;
    hdr_view[{cnt_e, 3'b000} +: 8] = item.byte_value;
    sect_len = hdr_view[HW-1:48];

    position_next          = pos_e;
    phase_next             = phase_e;
    hdr_count_next         = cnt_e;
    header_shift_next      = header_shift;
    section_remaining_next = rem_e;
    error_latched_next     = err_e;
    finished_next          = fin_e;
    version_latch_next     = ver_e;
    step                   = '0;

    if (!(err_e || fin_e)) begin
      unique case (phase_e)
        PH_FILE: begin
          if (cnt_e == 4'd0 && cfg.file_length < 32'(scd_pkg::FILE_HDR_BYTES)) begin
            error_latched_next     = 1'b1;
            step.emit              = 1'b1;
            step.result.kind       = scd_pkg::KIND_ERROR;
            step.result.error_code = scd_pkg::ERR_SHORT_FILE;
          end else begin
            header_shift_next = hdr_view;
            hdr_count_next    = cnt_e + 4'd1;
            position_next     = pos_inc;
            if (cnt_e == 4'(scd_pkg::FILE_HDR_BYTES - 1)) begin
              if (hdr_view[31:0] != cfg.magic_word) begin
                error_latched_next     = 1'b1;
                step.emit              = 1'b1;
                step.result.kind       = scd_pkg::KIND_ERROR;
                step.result.error_code = scd_pkg::ERR_BAD_MAGIC;
              end else begin
                version_latch_next        = hdr_view[63:32];
                phase_next                = PH_SECT;
                hdr_count_next            = '0;
                finished_next             = done;
                step.emit                 = 1'b1;
                step.result.kind          = scd_pkg::KIND_HEADER;
                step.result.file_version  = hdr_view[63:32];
                step.result.file_done     = done;
              end
            end
          end
        end
        PH_SECT: begin
          if (cnt_e == 4'd0 && left_now < 32'(scd_pkg::SECT_HDR_BYTES)) begin
            error_latched_next     = 1'b1;
            step.emit              = 1'b1;
            step.result.kind       = scd_pkg::KIND_ERROR;
            step.result.error_code = scd_pkg::ERR_SHORT_TRAILING;
          end else begin
            header_shift_next = hdr_view;
            hdr_count_next    = cnt_e + 4'd1;
            position_next     = pos_inc;
            if (cnt_e == 4'(scd_pkg::SECT_HDR_BYTES - 1)) begin
              if (sect_len > {32'd0, left_next}) begin
                error_latched_next     = 1'b1;
                step.emit              = 1'b1;
                step.result.kind       = scd_pkg::KIND_ERROR;
                step.result.error_code = scd_pkg::ERR_LENGTH_OVERRUN;
              end else begin
                hdr_count_next              = '0;
                step.emit                   = 1'b1;
                step.result.kind            = scd_pkg::KIND_SECTION;
                step.result.file_version    = ver_e;
                step.result.section_tag     = hdr_view[31:0];
                step.result.section_version = hdr_view[47:32];
                step.result.section_length  = sect_len;
                if (sect_len == 64'd0) begin
                  // An empty section closes at once.
                  finished_next         = done;
                  step.result.file_done = done;
                end else begin
                  phase_next             = PH_PAY;
                  section_remaining_next = sect_len;
                end
              end
            end
          end
        end
        PH_PAY: begin
          position_next            = pos_inc;
          step.emit                = 1'b1;
          step.result.kind         = scd_pkg::KIND_PAYLOAD;
          step.result.file_version = ver_e;
          step.result.payload_byte = item.byte_value;
          if (rem_e != 64'd0) begin
            section_remaining_next = rem_e - 64'd1;
          end
          if (rem_e <= 64'd1) begin
            phase_next               = PH_SECT;
            hdr_count_next           = '0;
            finished_next            = done;
            step.result.payload_last = 1'b1;
            step.result.file_done    = done;
          end
        end
        default: begin
          phase_next = phase_e;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position          <= '0;
      phase             <= PH_FILE;
      hdr_count         <= '0;
      section_remaining <= '0;
      error_latched     <= 1'b0;
      finished          <= 1'b0;
      version_latch     <= '0;
    end else if (fire) begin
      position          <= position_next;
      phase             <= phase_next;
      hdr_count         <= hdr_count_next;
      section_remaining <= section_remaining_next;
      error_latched     <= error_latched_next;
      finished          <= finished_next;
      version_latch     <= version_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      header_shift <= header_shift_next;
    end
  end

  // Once an error or a clean end is latched, nothing comes out until a new file.
  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    (error_latched && !item.start_of_file) |-> !step.emit)
    else $error("result produced after a latched error");

  a_silent_after_end: assert property (@(posedge clk) disable iff (rst)
    (finished && !item.start_of_file) |-> !step.emit)
    else $error("result produced after the end of file");

  // A bad magic leaves the count at the full header size, but only with an error latched.
  a_file_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FILE && !error_latched) |-> (hdr_count < 4'(scd_pkg::FILE_HDR_BYTES)))
    else $error("file header byte count out of range");

  a_payload_has_length: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY && !error_latched && !finished) |-> (section_remaining != 64'd0))
    else $error("payload phase with no bytes remaining");

endmodule

`default_nettype wire

>>> src/scd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module scd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire scd_pkg::step_t   step,
  input  wire logic             result_ready,
  output logic                  result_valid,
  output scd_pkg::result_t      result,
  output logic                  space
);

  // The register can take a new beat when it is empty or being drained.
  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step.emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      result <= step.result;
    end
  end

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == scd_pkg::KIND_ERROR)
      |-> (result.file_version == 32'd0 && !result.file_done))
    else $error("error result carries version or done mark");

  a_last_on_payload: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.payload_last) |-> (result.kind == scd_pkg::KIND_PAYLOAD))
    else $error("last mark on a result that is not a payload byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !advance)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

>>> src/section_container_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     scd_pkg::item_t (byte, start of file)
// result    out        result_valid / result_ready scd_pkg::result_t
// config    in         cfg_we (no wait)            cfg_index, cfg_data (32 bits)
//
// One byte is taken per cycle when the result side keeps up; an accepted beat
// passes through the input register and then the result register.
// The per-byte work is one position add, two remaining-length subtractions and
// compares, and a header byte insert, all between the two registers.
// Reset is synchronous: it clears the parser state except the header byte store,
// the valid flags and both configuration registers.
// item_ready drops only when the input register holds a beat and the result
// register is full and not being taken.

module section_container_deframer_unit #(
  parameter int POSITION_WIDTH = scd_pkg::POSITION_WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire scd_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output scd_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [31:0]      cfg_data
);

  scd_pkg::cfg_t  cfg;
  scd_pkg::item_t stage_item;
  scd_pkg::step_t step;
  logic           stage_valid;
  logic           space;
  logic           stage_fire;

  // Configuration registers. They must be written only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scd_pkg::REG_MAGIC_WORD:  cfg.magic_word  <= cfg_data;
        scd_pkg::REG_FILE_LENGTH: cfg.file_length <= cfg_data;
        default:                  cfg             <= cfg;
      endcase
    end
  end

  // The staged beat is processed when the result register has room for
  // whatever it might produce.
  assign stage_fire = stage_valid && space;
  assign item_ready = !stage_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  scd_parse #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (stage_fire),
    .item (stage_item),
    .cfg  (cfg),
    .step (step)
  );

  scd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (stage_fire),
    .step         (step),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .space        (space)
  );

endmodule

`default_nettype wire
